/* rtl/lms_pkg.sv */
`default_nettype none

package lms_pkg;

   localparam int ROWS = 8;
   localparam int ROW_W = 3;
   localparam int LAMP_W = 8;
   localparam int FRAME_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [LAMP_W-1:0] LAMP_RESET = 8'h01;
   localparam logic [LAMP_W-1:0] DRIVEN_COLS = 8'h1F;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] REG_BLANK_TICKS = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SETTLE_TICKS = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_MIN = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_STEP = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_LEVEL = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_ROW_INVERT = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_COL_INVERT = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_COL_BYTE_HIGH = 3'd7;

   typedef enum logic [1:0] {
      PH_BLANK = 2'd0,
      PH_SETTLE = 2'd1,
      PH_PULSE = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

endpackage

`default_nettype wire

/* rtl/lamp_matrix_row_scanner.sv */
// an accepted transfer passes through the item stage and then the output register before its result is shown
// throughput: one tick or one lamp write per cycle while rsp_tready does not hold the output register
// the lamp store is read when a transfer is accepted, at the row the scan reaches next
// reset: synchronous, active high; config and control registers return to their defaults, scan restarts at row 0
// blank phase, lamp rows read 0x01 until written (per-row valid bits)
`default_nettype none

module lamp_matrix_row_scanner (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // row_select[2:0], lamp_bits[10:3], zero fill
   input  wire logic [lms_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // frame[15:0], scan_row[18:16], scan_phase[20:19], zero fill
   output logic [lms_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // frame_strobe
   output logic                                    rsp_tuser,
   input  wire logic                               csr_we,
   input  wire logic [lms_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [lms_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lms_pkg::*;

   logic [15:0] blank_ticks_ff, settle_ticks_ff;
   logic [11:0] pulse_min_ff, pulse_step_ff;
   logic [3:0]  pulse_level_ff;
   logic        row_invert_ff, col_invert_ff, col_byte_high_ff;

   logic [LAMP_W-1:0] mem [ROWS];
   logic [ROWS-1:0]   lamp_valid_ff;
   logic [LAMP_W-1:0] rd_data_ff;
   logic              byp_ff;
   logic [LAMP_W-1:0] byp_data_ff;

   logic              s1_valid_ff;
   logic              s1_cmd_ff;
   logic [ROW_W-1:0]  s1_sel_ff;
   logic [LAMP_W-1:0] s1_bits_ff;
   logic [ROW_W-1:0]  s1_rd_addr_ff;

   logic [ROW_W-1:0]  row_ff, row_in;
   phase_type         phase_ff, phase_in;
   logic [15:0]       timer_ff, timer_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;

   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_strobe_ff, strobe_in;

   logic              advance, req_accept, s1_exec, s1_write;
   logic [ROW_W-1:0]  rd_addr;
   logic [LAMP_W-1:0] lamp;
   logic [LAMP_W-1:0] cols;
   logic [LAMP_W-1:0] rmask;
   phase_type         eff_phase;
   logic [15:0]       dur, timer_cur, timer_dec;
   logic [15:0]       pulse_prod;
   logic [15:0]       pulse_dur;
   logic [LAMP_W-1:0] frame_rows, frame_cols, rb, cb;
   logic [ROW_W-1:0]  shown_row;
   phase_type         shown_phase;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign s1_exec = s1_valid_ff && advance;
   assign s1_write = s1_exec && (s1_cmd_ff == CMD_WRITE);
   assign rd_addr = row_in;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ticks_ff <= 16'd2000;
         settle_ticks_ff <= 16'd20000;
         pulse_min_ff <= 12'd50;
         pulse_step_ff <= 12'd50;
         pulse_level_ff <= 4'd4;
         row_invert_ff <= 1'b0;
         col_invert_ff <= 1'b0;
         col_byte_high_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_BLANK_TICKS:   blank_ticks_ff <= csr_wdata;
            REG_SETTLE_TICKS:  settle_ticks_ff <= csr_wdata;
            REG_PULSE_MIN:     pulse_min_ff <= csr_wdata[11:0];
            REG_PULSE_STEP:    pulse_step_ff <= csr_wdata[11:0];
            REG_PULSE_LEVEL:   pulse_level_ff <= csr_wdata[3:0];
            REG_ROW_INVERT:    row_invert_ff <= csr_wdata[0];
            REG_COL_INVERT:    col_invert_ff <= csr_wdata[0];
            REG_COL_BYTE_HIGH: col_byte_high_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // lamp store
   always_ff @(posedge clock) begin
      if (s1_write) begin
         mem[s1_sel_ff] <= s1_bits_ff;
      end
      if (req_accept) begin
         rd_data_ff <= mem[rd_addr];
         byp_data_ff <= s1_bits_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_valid_ff <= '0;
         byp_ff <= 1'b0;
      end else begin
         if (s1_write) begin
            lamp_valid_ff[s1_sel_ff] <= 1'b1;
         end
         if (req_accept) begin
            byp_ff <= s1_write && (s1_sel_ff == rd_addr);
         end
      end
   end

   // item stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff <= req_tuser;
         s1_sel_ff <= req_tdata[2:0];
         s1_bits_ff <= req_tdata[10:3];
         s1_rd_addr_ff <= rd_addr;
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         phase_ff <= PH_BLANK;
         timer_ff <= '0;
         frame_ff <= '0;
      end else begin
         row_ff <= row_in;
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         frame_ff <= frame_in;
      end
   end

   assign lamp = byp_ff ? byp_data_ff
               : (lamp_valid_ff[s1_rd_addr_ff] ? rd_data_ff : LAMP_RESET);
   assign cols = lamp & DRIVEN_COLS;
   assign rmask = LAMP_W'(1) << row_ff;
   assign pulse_prod = 16'(pulse_level_ff) * 16'(pulse_step_ff);
   assign pulse_dur = 16'(pulse_min_ff) + pulse_prod;
   assign rb = row_invert_ff ? ~frame_rows : frame_rows;
   assign cb = col_invert_ff ? ~frame_cols : frame_cols;

   always_comb begin
      row_in = row_ff;
      phase_in = phase_ff;
      timer_in = timer_ff;
      frame_in = frame_ff;
      strobe_in = 1'b0;
      eff_phase = phase_ff;
      frame_rows = '0;
      frame_cols = '0;
      dur = 16'd1;
      timer_cur = timer_ff;
      timer_dec = timer_ff - 16'd1;
      shown_row = row_ff;
      shown_phase = phase_ff;
      if (s1_exec && (s1_cmd_ff == CMD_TICK)) begin
         if (timer_ff == 16'd0) begin
            if ((phase_ff == PH_PULSE) && (cols == '0)) begin
               eff_phase = PH_RELEASE;
            end
            unique case (eff_phase)
               PH_BLANK: begin
                  dur = blank_ticks_ff;
               end
               PH_SETTLE: begin
                  frame_rows = rmask;
                  dur = settle_ticks_ff;
               end
               PH_PULSE: begin
                  frame_rows = rmask;
                  frame_cols = cols;
                  dur = pulse_dur;
               end
               PH_RELEASE: begin
                  dur = 16'd1;
               end
               default: ;
            endcase
            frame_in = col_byte_high_ff ? {cb, rb} : {rb, cb};
            timer_cur = (dur == 16'd0) ? 16'd1 : dur;
            strobe_in = 1'b1;
         end
         shown_phase = eff_phase;
         timer_dec = timer_cur - 16'd1;
         timer_in = timer_dec;
         phase_in = eff_phase;
         if (timer_dec == 16'd0) begin
            if (eff_phase == PH_RELEASE) begin
               phase_in = PH_BLANK;
               row_in = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + ROW_W'(1);
            end else begin
               phase_in = phase_type'(eff_phase + 2'd1);
            end
         end
      end
      rsp_data_in = {3'b000, 2'(shown_phase), shown_row, frame_in};
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_exec) begin
         rsp_data_ff <= rsp_data_in;
         rsp_strobe_ff <= strobe_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_strobe_ff;

endmodule

`default_nettype wire
